FILE: src/nngr_pkg.sv
package nngr_pkg;

    // Size limits of the scaler.
    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int MAX_DST_DIM    = 4096;

    // Register widths.
    localparam int SW_W       = 9;
    localparam int SH_W       = 9;
    localparam int DW_W       = 13;
    localparam int DH_W       = 13;
    localparam int ALPHA_W    = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd4;

    // Item kinds carried in s_tuser.
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    // Pixel fields.
    localparam int COLOR_W    = 8;
    localparam int GRAY_W     = 8;
    localparam int POS_W      = $clog2(MAX_DST_DIM);
    localparam int S_TDATA_W  = 3 * COLOR_W;
    localparam int M_TDATA_W  = GRAY_W + ALPHA_W + 2 * POS_W;
    localparam int COL_LSB    = GRAY_W + ALPHA_W;
    localparam int ROW_LSB    = COL_LSB + POS_W;

    // Pixel store.
    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);

    // Division by three as a multiplication by a rounded-up reciprocal.
    localparam int SUM_W      = COLOR_W + 2;
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int PROD_W     = SUM_W + 10;

    // Source coordinate divider.
    localparam int QUOT_W      = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
                                 $clog2(MAX_SRC_WIDTH) : $clog2(MAX_SRC_HEIGHT);
    localparam int DIVIDEND_W  = POS_W + SW_W;
    localparam int DIVISOR_W   = DW_W;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Clamped dimensions and alpha as seen by the datapath.
    typedef struct packed {
        logic [SW_W-1:0]    src_width;
        logic [SH_W-1:0]    src_height;
        logic [DW_W-1:0]    dst_width;
        logic [DH_W-1:0]    dst_height;
        logic [ALPHA_W-1:0] alpha;
    } cfg_t;

    // One classified item on its way to the back end.
    typedef struct packed {
        logic              func;
        logic [GRAY_W-1:0] gray;
        logic [ADDR_W-1:0] load_addr;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic              last;
    } job_t;

    function automatic logic [SW_W-1:0] clamp_src(input logic [SW_W-1:0] v, input int maxv);
        logic [SW_W-1:0] r;
        if (v == '0) begin
            r = SW_W'(1);
        end else if (int'(v) > maxv) begin
            r = SW_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [DW_W-1:0] clamp_dst(input logic [DW_W-1:0] v, input int maxv);
        logic [DW_W-1:0] r;
        if (v == '0) begin
            r = DW_W'(1);
        end else if (int'(v) > maxv) begin
            r = DW_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: src/nngr_queue.sv
module nngr_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_en,
    input  nngr_pkg::job_t push_data,
    output logic          full,
    input  logic          pop_en,
    output nngr_pkg::job_t pop_data,
    output logic          empty
);
    import nngr_pkg::*;

    job_t                   slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_en) begin
            slot[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_en && !pop_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_en && !push_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/nngr_front.sv
module nngr_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  nngr_pkg::cfg_t                    cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic                              s_tuser,
    input  logic [nngr_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              q_full,
    output logic                              push_en,
    output nngr_pkg::job_t                    push_data
);
    import nngr_pkg::*;

    logic [ADDR_W-1:0]  load_pos_reg;
    logic [POS_W-1:0]   col_reg;
    logic [POS_W-1:0]   row_reg;

    logic [TOTAL_W-1:0] total;
    logic [ADDR_W-1:0]  load_cur;
    logic [TOTAL_W-1:0] load_inc;
    logic [ADDR_W-1:0]  load_next;
    logic [POS_W-1:0]   col_cur;
    logic [POS_W-1:0]   row_cur;
    logic               col_end;
    logic               row_end;
    logic [SUM_W-1:0]   sum;
    logic [PROD_W-1:0]  prod;

    assign s_tready = !q_full;
    assign push_en  = s_tvalid && !q_full;

    always_comb begin
        total    = TOTAL_W'(cfg.src_width) * TOTAL_W'(cfg.src_height);
        // A position left over from a larger frame restarts at zero.
        load_cur = ({1'b0, load_pos_reg} >= total) ? '0 : load_pos_reg;
        load_inc = TOTAL_W'(load_cur) + 1'b1;
        load_next = (load_inc >= total) ? '0 : load_inc[ADDR_W-1:0];

        col_cur = ({1'b0, col_reg} >= cfg.dst_width)  ? '0 : col_reg;
        row_cur = ({1'b0, row_reg} >= cfg.dst_height) ? '0 : row_reg;
        col_end = ({1'b0, col_cur} == (cfg.dst_width - 1'b1));
        row_end = ({1'b0, row_cur} == (cfg.dst_height - 1'b1));

        sum  = SUM_W'(s_tdata[0 +: COLOR_W]) + SUM_W'(s_tdata[COLOR_W +: COLOR_W])
             + SUM_W'(s_tdata[2*COLOR_W +: COLOR_W]);
        prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);

        push_data.func      = s_tuser;
        push_data.gray      = prod[DIV3_SHIFT +: GRAY_W];
        push_data.load_addr = load_cur;
        push_data.col       = col_cur;
        push_data.row       = row_cur;
        push_data.last      = col_end && row_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
        end else if (push_en) begin
            if (s_tuser == FUNC_LOAD) begin
                load_pos_reg <= load_next;
            end else if (col_end) begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_cur + 1'b1;
            end else begin
                col_reg <= col_cur + 1'b1;
                row_reg <= row_cur;
            end
        end
    end

endmodule

FILE: src/nngr_div.sv
module nngr_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [nngr_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [nngr_pkg::DIVISOR_W-1:0]    divisor,
    output logic                              busy,
    output logic [nngr_pkg::QUOT_W-1:0]       quotient
);
    import nngr_pkg::*;

    localparam int DEN_W = DIVISOR_W + QUOT_W - 1;
    localparam int CNT_W = $clog2(QUOT_W + 1);

    // The quotient is known to fit in QUOT_W bits, so the divisor starts
    // aligned under the top quotient bit and one bit is settled per cycle.
    logic [DIVIDEND_W-1:0] rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [QUOT_W-1:0]     q_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  fits;

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;
    assign fits     = (rem_reg >= DIVIDEND_W'(den_reg));

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            den_reg <= DEN_W'(divisor) << (QUOT_W - 1);
            q_reg   <= '0;
        end else if (busy) begin
            if (fits) begin
                rem_reg <= rem_reg - DIVIDEND_W'(den_reg);
            end
            den_reg <= den_reg >> 1;
            q_reg   <= {q_reg[QUOT_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CNT_W'(QUOT_W);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: src/nngr_back.sv
module nngr_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  nngr_pkg::cfg_t                    cfg,
    input  logic                              q_empty,
    input  nngr_pkg::job_t                    q_job,
    output logic                              pop_en,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nngr_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import nngr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;

    logic [GRAY_W-1:0] store [STORE_DEPTH];

    logic [POS_W-1:0]  col_reg;
    logic [POS_W-1:0]  row_reg;
    logic              last_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              m_valid_reg;
    logic [GRAY_W-1:0] m_gray_reg;
    logic [ALPHA_W-1:0] m_alpha_reg;
    logic [POS_W-1:0]  m_col_reg;
    logic [POS_W-1:0]  m_row_reg;
    logic              m_last_reg;

    logic              div_start;
    logic              store_we;
    logic              out_load;
    logic              out_free;
    logic              col_busy;
    logic              row_busy;
    logic [QUOT_W-1:0] src_x;
    logic [QUOT_W-1:0] src_y;
    logic [DIVIDEND_W-1:0] col_dividend;
    logic [DIVIDEND_W-1:0] row_dividend;
    logic [ADDR_W:0]   addr_sum;

    assign col_dividend = DIVIDEND_W'(q_job.col) * DIVIDEND_W'(cfg.src_width);
    assign row_dividend = DIVIDEND_W'(q_job.row) * DIVIDEND_W'(cfg.src_height);

    nngr_div u_col_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (col_dividend),
        .divisor  (cfg.dst_width),
        .busy     (col_busy),
        .quotient (src_x)
    );

    nngr_div u_row_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (row_dividend),
        .divisor  (cfg.dst_height),
        .busy     (row_busy),
        .quotient (src_y)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign addr_sum = (ADDR_W + 1)'(src_y) * (ADDR_W + 1)'(cfg.src_width)
                    + (ADDR_W + 1)'(src_x);

    always_comb begin
        state_next = state_reg;
        pop_en     = 1'b0;
        div_start  = 1'b0;
        store_we   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    pop_en = 1'b1;
                    if (q_job.func == FUNC_EMIT) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        store_we = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (!col_busy && !row_busy) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start) begin
            col_reg  <= q_job.col;
            row_reg  <= q_job.row;
            last_reg <= q_job.last;
        end
        if (state_reg == ST_DIV) begin
            addr_reg <= addr_sum[ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store[q_job.load_addr] <= q_job.gray;
        end
    end

    // The read port lands straight in the output register.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_gray_reg <= store[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_alpha_reg <= cfg.alpha;
            m_col_reg   <= col_reg;
            m_row_reg   <= row_reg;
            m_last_reg  <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_row_reg, m_col_reg, m_alpha_reg, m_gray_reg};
    assign m_tlast  = m_last_reg;

endmodule

FILE: src/nearest_neighbor_gray_resize_top.sv
// Nearest-neighbour scaler with grayscale conversion.
// The s_ channel takes items of two kinds, told apart by s_tuser: a load
// (s_tuser low) stores the gray level of one source pixel in raster order,
// an emit (s_tuser high) produces the next output pixel on the m_ channel,
// with m_tlast on the final pixel of the output frame.
// Loads are taken one per cycle while the queue is not full. In the back
// end an emit is dequeued, the bit-serial source column and row dividers
// settle one quotient bit per cycle, the store address is registered and,
// once the output register is free, the store is read directly into it.
// A four-entry queue separates the input side from the back end, so input
// transfers continue while an emit is being worked out or waits to leave.
// If the receiver holds m_tready low, the output register keeps its pixel,
// the back end stops at the next emit's store read, and s_tready falls
// once the queue has filled. Reset clears the load position and the emit
// counters and returns the registers to their defaults; the pixel store is
// not cleared and must be loaded before it is read. Registers are written
// through cfg_wr_en, cfg_index and cfg_wdata; the user must write them
// only while no item is in flight, and the block itself does not enforce it.
module nearest_neighbor_gray_resize_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: red [7:0], green [15:8], blue [23:16]
    input  logic [nngr_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: func (0 load, 1 emit)
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: gray [7:0], alpha_out [15:8], out_col [27:16], out_row [39:28]
    output logic [nngr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [nngr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nngr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import nngr_pkg::*;

    logic [SW_W-1:0]    src_width_reg;
    logic [SH_W-1:0]    src_height_reg;
    logic [DW_W-1:0]    dst_width_reg;
    logic [DH_W-1:0]    dst_height_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    cfg_t  cfg;
    logic  q_full;
    logic  q_empty;
    logic  push_en;
    logic  pop_en;
    job_t  push_data;
    job_t  q_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= SW_W'(256);
            src_height_reg <= SH_W'(256);
            dst_width_reg  <= DW_W'(256);
            dst_height_reg <= DH_W'(256);
            alpha_reg      <= ALPHA_W'(255);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[SW_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_wdata[SH_W-1:0];
                CFG_DST_WIDTH:  dst_width_reg  <= cfg_wdata[DW_W-1:0];
                CFG_DST_HEIGHT: dst_height_reg <= cfg_wdata[DH_W-1:0];
                CFG_ALPHA:      alpha_reg      <= cfg_wdata[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The registers keep the bits written; the datapath sees them clamped.
    always_comb begin
        cfg.src_width  = clamp_src(src_width_reg, MAX_SRC_WIDTH);
        cfg.src_height = clamp_src(src_height_reg, MAX_SRC_HEIGHT);
        cfg.dst_width  = clamp_dst(dst_width_reg, MAX_DST_DIM);
        cfg.dst_height = clamp_dst(dst_height_reg, MAX_DST_DIM);
        cfg.alpha      = alpha_reg;
    end

    nngr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push_en   (push_en),
        .push_data (push_data)
    );

    nngr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (push_en),
        .push_data (push_data),
        .full      (q_full),
        .pop_en    (pop_en),
        .pop_data  (q_job),
        .empty     (q_empty)
    );

    nngr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_job     (q_job),
        .pop_en    (pop_en),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_last_on_final_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |->
            ({1'b0, m_tdata[COL_LSB +: POS_W]} == (cfg.dst_width - 1'b1)) &&
            ({1'b0, m_tdata[ROW_LSB +: POS_W]} == (cfg.dst_height - 1'b1)))
        else $error("last flag on a pixel that is not the final one");
    a_col_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[COL_LSB +: POS_W]} < cfg.dst_width))
        else $error("output column outside the output width");
    a_row_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[ROW_LSB +: POS_W]} < cfg.dst_height))
        else $error("output row outside the output height");
`endif

endmodule
